/* design/heatmap_topk_keypoint_select_unit_macros.svh */
// Assertion macros shared by the keypoint selection RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HEATMAP_TOPK_KEYPOINT_SELECT_UNIT_MACROS_SVH
`define HEATMAP_TOPK_KEYPOINT_SELECT_UNIT_MACROS_SVH

// same-cycle implication
`define HKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hksel_pkg.sv */
// Shared types and constants for the heatmap top-K keypoint selection unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hksel_pkg;

  localparam int COORD_BITS = 12;
  localparam int SCORE_BITS = 16;
  localparam int CELL_BITS  = 9;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_BORDER    = 3'd1;
  localparam logic [2:0] CFG_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_MAP_H     = 3'd3;
  localparam logic [2:0] CFG_MAP_W     = 3'd4;
  localparam logic [2:0] CFG_GRID_H    = 3'd5;
  localparam logic [2:0] CFG_GRID_W    = 3'd6;

  // score in the top bits so a plain compare ranks score, then row, then column
  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } hksel_entry_t;

  typedef struct packed {
    hksel_entry_t entry;
    logic         cand;
    logic         last;
  } hksel_item_t;

endpackage

`default_nettype wire

/* design/heatmap_topk_keypoint_select_unit.sv */
// Top level of the heatmap top-K keypoint selection unit.
// Holds the configuration registers; uses hksel_pkg, hksel_front, hksel_queue, hksel_back.
//
//   channel  | direction | tdata                                   | tuser    | tlast
//   s_axis   | in        | pixel_row, pixel_col, pixel_score       | -        | frame_end
//   m_axis   | out       | kp_row, kp_col, kp_score, cell_row/col  | kp_valid | kp_last
//   cfg      | in        | cfg_data_i written to cfg_idx_i when cfg_we_i
//
// Pixels enter at one per cycle while the queue has room; each is ranked into the
// MAX_KEEP-entry list by parallel compares against every slot, so the back end retires
// one word per cycle. A frame_end word starts emission of max(n, 1) words for n kept
// keypoints, capped at limit, which pauses ranking; the four-word queue then fills and
// s_axis_tready drops. Output stalls hold the result register and, through the queue, the input.
// Reset loads the register defaults and empties the queue and the list; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module heatmap_topk_keypoint_select_unit
  import hksel_pkg::*;
#(
  parameter int MAX_KEEP   = 64,
  parameter int CELL_SHIFT = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // pixel_row[11:0], pixel_col[23:12], pixel_score[39:24]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // kp_row[11:0], kp_col[23:12], kp_score[39:24],
                                           // cell_row[48:40], cell_col[57:49], zero[63:58]
  output logic             m_axis_tuser,   // kp_valid[0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [SCORE_BITS-1:0] threshold_q;
  logic [7:0]            border_q;
  logic [6:0]            limit_q;
  logic [12:0]           map_h_q;
  logic [12:0]           map_w_q;
  logic [9:0]            grid_h_q;
  logic [9:0]            grid_w_q;

  hksel_item_t push_item;
  hksel_item_t pop_item;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 16'd1;
      border_q    <= 8'd4;
      limit_q     <= 7'd64;
      map_h_q     <= 13'd480;
      map_w_q     <= 13'd640;
      grid_h_q    <= 10'd60;
      grid_w_q    <= 10'd80;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_BORDER:    border_q    <= cfg_data_i[7:0];
        CFG_LIMIT:     limit_q     <= cfg_data_i[6:0];
        CFG_MAP_H:     map_h_q     <= cfg_data_i[12:0];
        CFG_MAP_W:     map_w_q     <= cfg_data_i[12:0];
        CFG_GRID_H:    grid_h_q    <= cfg_data_i[9:0];
        CFG_GRID_W:    grid_w_q    <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  hksel_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .threshold_i (threshold_q),
    .border_i    (border_q),
    .map_h_i     (map_h_q),
    .map_w_i     (map_w_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .item_o      (push_item)
  );

  hksel_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  hksel_back #(
    .MAX_KEEP   (MAX_KEEP),
    .CELL_SHIFT (CELL_SHIFT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (pop_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .limit_i     (limit_q),
    .grid_h_i    (grid_h_q),
    .grid_w_i    (grid_w_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* design/hksel_front.sv */
// Front end: accepts score pixels and classifies them as candidates.
// Uses hksel_pkg; feeds hksel_queue.
`timescale 1ns / 1ps
`default_nettype none

module hksel_front
  import hksel_pkg::*;
(
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [39:0]           in_data_i,
  input  wire logic                  in_last_i,
  input  wire logic [SCORE_BITS-1:0] threshold_i,
  input  wire logic [7:0]            border_i,
  input  wire logic [12:0]           map_h_i,
  input  wire logic [12:0]           map_w_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output hksel_item_t                item_o
);

  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;
  logic [SCORE_BITS-1:0] score;
  logic [13:0]           row_end;
  logic [13:0]           col_end;
  logic                  row_in;
  logic                  col_in;

  assign row   = in_data_i[11:0];
  assign col   = in_data_i[23:12];
  assign score = in_data_i[39:24];

  assign row_end = 14'(row) + 14'(border_i);
  assign col_end = 14'(col) + 14'(border_i);
  assign row_in  = (row >= 12'(border_i)) && (row_end < 14'(map_h_i));
  assign col_in  = (col >= 12'(border_i)) && (col_end < 14'(map_w_i));

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    item_o.entry.score = score;
    item_o.entry.row   = row;
    item_o.entry.col   = col;
    item_o.cand        = row_in && col_in && (score > threshold_i);
    item_o.last        = in_last_i;
  end

endmodule

`default_nettype wire

/* design/hksel_queue.sv */
// Short queue between the classifying front and the ranking back end.
// Uses hksel_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hksel_queue
  import hksel_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire hksel_item_t push_item_i,
  input  wire logic  pop_i,
  output hksel_item_t pop_item_o,
  output logic       full_o,
  output logic       empty_o
);

  hksel_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     fill_q, fill_d;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + QPTR_W'(do_pop);
    fill_d   = fill_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* design/hksel_back.sv */
// Back end: sorted insertion list of candidates and the per-frame emitter
// with its output register. Uses hksel_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "heatmap_topk_keypoint_select_unit_macros.svh"

module hksel_back
  import hksel_pkg::*;
#(
  parameter int MAX_KEEP   = 64,
  parameter int CELL_SHIFT = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hksel_item_t      item_i,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  input  wire logic [6:0]       limit_i,
  input  wire logic [9:0]       grid_h_i,
  input  wire logic [9:0]       grid_w_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [63:0]           out_data_o,
  output logic                  out_user_o,
  output logic                  out_last_o
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                  state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  hksel_entry_t          cell_q [MAX_KEEP];
  hksel_entry_t          cell_d [MAX_KEEP];
  hksel_entry_t          prev_cell [MAX_KEEP];
  logic [MAX_KEEP-1:0]   ins;
  logic [MAX_KEEP-1:0]   prev_ins;
  logic                  do_ins;
  logic [CNT_W-1:0]      count_after;
  logic [CNT_W-1:0]      lim;
  logic [CNT_W-1:0]      n_emit;
  logic                  out_load;

  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_row_q, out_row_d;
  logic [COORD_BITS-1:0] out_col_q, out_col_d;
  logic [SCORE_BITS-1:0] out_score_q, out_score_d;
  logic [CELL_BITS-1:0]  out_crow_q, out_crow_d;
  logic [CELL_BITS-1:0]  out_ccol_q, out_ccol_d;
  logic                  out_kv_q, out_kv_d;
  logic                  out_last_q, out_last_d;

  logic [COORD_BITS-1:0] row_cell;
  logic [COORD_BITS-1:0] col_cell;
  logic [9:0]            top_h;
  logic [9:0]            top_w;

  assign q_pop_o = (state_q == ST_RUN) && !q_empty_i;
  assign do_ins  = q_pop_o && item_i.cand;

  // slot i takes the new entry or its upper neighbor once the candidate ranks above it or the slot is past the count
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_rank
    assign ins[i] = (CNT_W'(i) >= count_q) || (item_i.entry > cell_q[i]);
    if (i == 0) begin : g_head
      assign prev_ins[i]  = 1'b0;
      assign prev_cell[i] = cell_q[i];
    end else begin : g_body
      assign prev_ins[i]  = ins[i-1];
      assign prev_cell[i] = cell_q[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      cell_d[i] = cell_q[i];
      if (out_load && (rem_q != '0)) begin
        // advance the list toward the head while emitting
        if (i < MAX_KEEP - 1) begin
          cell_d[i] = cell_q[(i + 1) % MAX_KEEP];
        end
      end else if (do_ins && ins[i]) begin
        cell_d[i] = prev_ins[i] ? prev_cell[i] : item_i.entry;
      end
    end
  end

  assign count_after = (count_q != CNT_W'(MAX_KEEP)) ? count_q + CNT_W'(1) : count_q;
  assign lim         = (limit_i > 7'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : CNT_W'(limit_i);

  always_comb begin
    n_emit = do_ins ? count_after : count_q;
    if (n_emit > lim) begin
      n_emit = lim;
    end
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    case (state_q)
      ST_RUN: begin
        if (q_pop_o && item_i.last) begin
          state_d = ST_EMIT;
          rem_d   = n_emit;
          count_d = '0;
        end else if (do_ins) begin
          count_d = count_after;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (rem_q <= CNT_W'(1)) begin
            state_d = ST_RUN;
          end
          if (rem_q != '0) begin
            rem_d = rem_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // descriptor cell: coordinate over the cell size, clamped to the grid
  assign top_h    = (grid_h_i == '0) ? '0 : grid_h_i - 10'd1;
  assign top_w    = (grid_w_i == '0) ? '0 : grid_w_i - 10'd1;
  assign row_cell = cell_q[0].row >> CELL_SHIFT;
  assign col_cell = cell_q[0].col >> CELL_SHIFT;

  always_comb begin
    if (rem_q == '0) begin
      out_row_d   = '0;
      out_col_d   = '0;
      out_score_d = '0;
      out_crow_d  = '0;
      out_ccol_d  = '0;
      out_kv_d    = 1'b0;
      out_last_d  = 1'b1;
    end else begin
      out_row_d   = cell_q[0].row;
      out_col_d   = cell_q[0].col;
      out_score_d = cell_q[0].score;
      out_crow_d  = (row_cell < 12'(top_h)) ? row_cell[CELL_BITS-1:0]
                                             : top_h[CELL_BITS-1:0];
      out_ccol_d  = (col_cell < 12'(top_w)) ? col_cell[CELL_BITS-1:0]
                                             : top_w[CELL_BITS-1:0];
      out_kv_d    = 1'b1;
      out_last_d  = (rem_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (out_load) begin
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_score_q <= out_score_d;
      out_crow_q  <= out_crow_d;
      out_ccol_q  <= out_ccol_d;
      out_kv_q    <= out_kv_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'd0, out_ccol_q, out_crow_q, out_score_q, out_col_q, out_row_q};
  assign out_user_o  = out_kv_q;
  assign out_last_o  = out_last_q;

  `HKS_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_KEEP), "list count above capacity")
  `HKS_ASSERT_NOW(a_emit_cleared, state_q == ST_EMIT, count_q == '0, "list not cleared in emit")
  `HKS_ASSERT_NEXT(a_last_returns, out_load && out_last_d, state_q == ST_RUN, "emit overran")
  `HKS_ASSERT_NOW(a_rem_cap, state_q == ST_EMIT, rem_q <= CNT_W'(MAX_KEEP), "emit count too big")

endmodule

`default_nettype wire
